FILE: rtl/ppoc_pkg.sv
// Package for the pulse period / on-time capture block.
// Holds codes, widths, the job and config types, and the state encodings.
// No dependencies.
package ppoc_pkg;

	localparam int CaptureW = 16;
	localparam int UsW      = 32;
	localparam int TickW    = 8;
	localparam logic [CaptureW-1:0] CounterMax = 16'd65535;

	// input item function codes
	localparam logic [1:0] FuncStart    = 2'd0;
	localparam logic [1:0] FuncOverflow = 2'd1;
	localparam logic [1:0] FuncEdge     = 2'd2;
	localparam logic [1:0] FuncPoll     = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CfgMeasureMode  = 2'd0;
	localparam logic [1:0] CfgTickTimeUs   = 2'd1;
	localparam logic [1:0] CfgTimeoutLimit = 2'd2;

	localparam logic StatusDone    = 1'b0;
	localparam logic StatusTimeout = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_ARMED = 3'b010,
		PH_FIRST = 3'b100
	} phase_t;

	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_SPAN  = 4'b0010,
		BK_TICKS = 4'b0100,
		BK_SCALE = 4'b1000
	} back_state_t;

	typedef struct packed {
		logic                measure_mode;
		logic [TickW-1:0]    tick_time_us;
		logic [UsW-1:0]      timeout_limit;
	} cfg_t;

	// one measurement handed from front to back
	typedef struct packed {
		logic                timeout;
		logic [CaptureW-1:0] first;
		logic [CaptureW-1:0] wraps;
		logic [CaptureW-1:0] second;
	} job_t;

endpackage

FILE: rtl/pulse_period_ontime_capture.sv
// Pulse period / on-time capture: front end, job queue, back end, config regs.
// Input items take one cycle each while the two-entry job queue has room.
// The item that completes a result passes as a job through the job queue and
// the back-end states SPAN, TICKS and SCALE before empty drops; the back end
// takes its next job only after the held result is popped, one job at a time.
// arst_n clears phase, counters, queues and loads register reset values.
module pulse_period_ontime_capture (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic        edge_rising,
	input  logic [15:0] capture_value,
	output logic        empty,
	input  logic        pop,
	output logic        status,
	output logic [31:0] measured_us,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ppoc_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic fe_push;
	job_t fe_job;
	logic q_full, q_valid, q_pop;
	job_t q_head;
	logic res_valid;

	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign full      = q_full;
	assign empty     = !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.measure_mode  <= 1'b0;
			cfg_q.tick_time_us  <= TickW'(4);
			cfg_q.timeout_limit <= UsW'(100000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgMeasureMode:  cfg_q.measure_mode  <= cfg_data[0];
				CfgTickTimeUs:   cfg_q.tick_time_us  <= cfg_data[TickW-1:0];
				CfgTimeoutLimit: cfg_q.timeout_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	ppoc_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .accept,
		.func, .edge_rising, .capture_value,
		.job_push(fe_push), .job(fe_job)
	);

	ppoc_jobq u_jobq (
		.clk, .arst_n, .push(fe_push), .push_job(fe_job), .pop(q_pop),
		.full(q_full), .valid(q_valid), .head(q_head)
	);

	ppoc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .job_valid(q_valid), .job(q_head),
		.job_pop(q_pop), .res_pop(pop), .res_valid,
		.res_status(status), .res_us(measured_us)
	);

endmodule

FILE: rtl/ppoc_front.sv
// Front end: takes input items, tracks arm/capture phase, wraps and poll ticks.
// Emits a job on a completed measurement or a timeout. Depends on ppoc_pkg.
module ppoc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ppoc_pkg::cfg_t           cfg,
	input  logic                     accept,
	input  logic [1:0]               func,
	input  logic                     edge_rising,
	input  logic [ppoc_pkg::CaptureW-1:0] capture_value,
	output logic                     job_push,
	output ppoc_pkg::job_t           job
);
	import ppoc_pkg::*;

	phase_t              phase_q, phase_d;
	logic [CaptureW-1:0] first_q, first_d;
	logic [CaptureW-1:0] wrap_q, wrap_d;
	logic [UsW-1:0]      poll_q, poll_d;
	logic [UsW-1:0]      poll_inc;
	logic                qualifies;

	assign poll_inc  = (poll_q != '1) ? poll_q + UsW'(1) : poll_q;
	assign qualifies = cfg.measure_mode ? !edge_rising : edge_rising;

	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		wrap_d   = wrap_q;
		poll_d   = poll_q;
		job_push = 1'b0;
		job      = '{timeout: StatusDone, first: first_q, wraps: wrap_q,
			second: capture_value};
		if (accept) begin
			unique case (func)
				FuncStart: begin
					phase_d = PH_ARMED;
					first_d = '0;
					wrap_d  = '0;
					poll_d  = '0;
				end
				FuncOverflow: begin
					if (phase_q == PH_FIRST && wrap_q != '1)
						wrap_d = wrap_q + CaptureW'(1);
				end
				FuncEdge: begin
					if (phase_q == PH_ARMED && edge_rising) begin
						first_d = capture_value;
						phase_d = PH_FIRST;
					end else if (phase_q == PH_FIRST && qualifies) begin
						job_push = 1'b1;
						phase_d  = PH_IDLE;
					end
				end
				FuncPoll: begin
					if (phase_q != PH_IDLE) begin
						poll_d = poll_inc;
						if (poll_inc >= cfg.timeout_limit) begin
							job_push    = 1'b1;
							job.timeout = StatusTimeout;
							phase_d     = PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= '0;
			wrap_q  <= '0;
			poll_q  <= '0;
		end else begin
			phase_q <= phase_d;
			first_q <= first_d;
			wrap_q  <= wrap_d;
			poll_q  <= poll_d;
		end
	end

endmodule

FILE: rtl/ppoc_jobq.sv
// Two-entry job queue between the front and back ends.
// Depends on ppoc_pkg for job_t.
module ppoc_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ppoc_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output ppoc_pkg::job_t head
);
	import ppoc_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/ppoc_back.sv
// Back end: turns a job into elapsed microseconds (wrap span, clamp, scale,
// saturate; zero on timeout) in its states and holds the result. Depends on ppoc_pkg.
module ppoc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppoc_pkg::cfg_t       cfg,
	input  logic                 job_valid,
	input  ppoc_pkg::job_t       job,
	output logic                 job_pop,
	input  logic                 res_pop,
	output logic                 res_valid,
	output logic                 res_status,
	output logic [ppoc_pkg::UsW-1:0] res_us
);
	import ppoc_pkg::*;

	localparam int ProdW = UsW + TickW;

	back_state_t          state_q;
	job_t                 job_q;
	logic [UsW-1:0]       up_q;
	logic [UsW-1:0]       ticks_q;
	logic [ProdW-1:0]     prod;
	logic                 res_valid_q;
	logic                 status_q;
	logic [UsW-1:0]       us_q;

	assign job_pop    = (state_q == BK_IDLE) && job_valid && !res_valid_q;
	assign prod       = ProdW'(ticks_q) * ProdW'(cfg.tick_time_us);
	assign res_valid  = res_valid_q;
	assign res_status = status_q;
	assign res_us     = us_q;

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job;
		// zero wraps gives a zero product, so one formula covers both cases
		if (state_q == BK_SPAN)
			up_q <= UsW'(job_q.wraps) * UsW'(CounterMax) + UsW'(job_q.second);
		if (state_q == BK_TICKS)
			ticks_q <= (up_q >= UsW'(job_q.first)) ? up_q - UsW'(job_q.first) : '0;
		if (state_q == BK_SCALE) begin
			status_q <= job_q.timeout;
			if (job_q.timeout)
				us_q <= '0;
			else if (prod[ProdW-1:UsW] != '0)
				us_q <= '1;
			else
				us_q <= prod[UsW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE:  if (job_pop) state_q <= BK_SPAN;
				BK_SPAN:  state_q <= BK_TICKS;
				BK_TICKS: state_q <= BK_SCALE;
				BK_SCALE: state_q <= BK_IDLE;
				default:  state_q <= BK_IDLE;
			endcase
			if (state_q == BK_SCALE)
				res_valid_q <= 1'b1;
			else if (res_pop)
				res_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/ppoc_checker.sv
// Port-level checks for pulse_period_ontime_capture, bound to the top level.
// Depends on ppoc_pkg for status codes.
module ppoc_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        status,
	input logic [31:0] measured_us
);
	import ppoc_pkg::*;

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(measured_us))
		else $error("result changed before transfer");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == StatusTimeout |-> measured_us == '0)
		else $error("timeout result with nonzero time");

	a_reset: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("queues not clear in reset");

endmodule

bind pulse_period_ontime_capture ppoc_port_checks u_ppoc_port_checks (.*);

FILE: dv/ppoc_checker.sv
// Checker for pulse_period_ontime_capture: watches the item, result and register channels,
// predicts each measurement or timeout and compares results in order.
// Depends on ppoc_pkg for widths, function codes, register indexes and status codes.
module ppoc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  func,
	input  logic        edge_rising,
	input  logic [15:0] capture_value,
	input  logic        empty,
	input  logic        pop,
	input  logic        status,
	input  logic [31:0] measured_us,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          awaiting
);
	import ppoc_pkg::*;

	typedef struct packed {
		logic           status;
		logic [UsW-1:0] us;
	} reading_t;

	reading_t expected_readings[$];
	reading_t want;

	// register copies
	logic                mode_ontime;
	logic [TickW-1:0]    tick_us;
	logic [UsW-1:0]      poll_limit;

	// measurement state
	phase_t              ph;
	logic [CaptureW-1:0] start_count;
	logic [CaptureW-1:0] wraps_seen;
	logic [31:0]         polls_seen;

	function automatic logic [UsW-1:0] span_us(logic [CaptureW-1:0] second);
		logic [63:0] cmax;
		logic [63:0] up;
		logic [63:0] ticks;
		logic [63:0] us;
		cmax = {48'd0, CounterMax};
		if (wraps_seen != '0) begin
			up = cmax + ({48'd0, wraps_seen} - 64'd1) * cmax + {48'd0, second};
		end else begin
			up = {48'd0, second};
		end
		// capture earlier than the first one with no wraps clamps to zero
		ticks = (up >= {48'd0, start_count}) ? up - {48'd0, start_count} : 64'd0;
		us = ticks * {56'd0, tick_us};
		return (us > 64'hFFFF_FFFF) ? '1 : us[UsW-1:0];
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("mismatch at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	task automatic take_item(logic [1:0] f, logic rising, logic [CaptureW-1:0] cap);
		reading_t r;
		case (f)
			FuncStart: begin
				ph = PH_ARMED;
				start_count = '0;
				wraps_seen = '0;
				polls_seen = '0;
			end
			FuncOverflow: begin
				if (ph == PH_FIRST && wraps_seen != '1)
					wraps_seen++;
			end
			FuncEdge: begin
				if (ph == PH_ARMED) begin
					if (rising) begin
						start_count = cap;
						ph = PH_FIRST;
					end
				end else if (ph == PH_FIRST && (mode_ontime ? !rising : rising)) begin
					r.status = StatusDone;
					r.us = span_us(cap);
					expected_readings.push_back(r);
					ph = PH_IDLE;
				end
			end
			default: begin
				if (ph != PH_IDLE) begin
					if (polls_seen != '1)
						polls_seen++;
					if (polls_seen >= poll_limit) begin
						r.status = StatusTimeout;
						r.us = '0;
						expected_readings.push_back(r);
						ph = PH_IDLE;
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_ontime = 1'b0;
			tick_us = 8'd4;
			poll_limit = 32'd100000;
			ph = PH_IDLE;
			start_count = '0;
			wraps_seen = '0;
			polls_seen = '0;
			expected_readings.delete();
			mismatches = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_readings.size() == 0) begin
					note_mismatch("result with nothing expected", measured_us, '0);
				end else begin
					want = expected_readings.pop_front();
					if (status !== want.status)
						note_mismatch("status", {31'd0, status}, {31'd0, want.status});
					if (measured_us !== want.us)
						note_mismatch("measured_us", measured_us, want.us);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgMeasureMode:  mode_ontime = cfg_data[0];
					CfgTickTimeUs:   tick_us = cfg_data[TickW-1:0];
					CfgTimeoutLimit: poll_limit = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				take_item(func, edge_rising, capture_value);
		end
		awaiting = expected_readings.size();
	end

endmodule

FILE: dv/pulse_period_ontime_capture_tb.sv
// Testbench top for pulse_period_ontime_capture: clock, reset, item and register
// stimulus with random idling, verdict. Prediction and compare live in ppoc_checker.
// Depends on ppoc_pkg, ppoc_checker and the block itself.
module pulse_period_ontime_capture_tb;
	import ppoc_pkg::*;

	localparam int CycleLimit     = 600000;
	localparam int SettleCycles   = 16;
	localparam int Phases         = 8;
	localparam int ItemsPerPhase  = 120;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  func;
	logic        edge_rising;
	logic [15:0] capture_value;
	logic        empty;
	logic        pop;
	logic        status;
	logic [31:0] measured_us;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int   mismatches;
	int   awaiting;
	int   cycle_count = 0;
	int   items_sent = 0;
	logic quiet = 1'b0;       // no idling on either side while set
	logic cur_mode = 1'b0;

	pulse_period_ontime_capture dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.edge_rising(edge_rising),
		.capture_value(capture_value),
		.empty(empty),
		.pop(pop),
		.status(status),
		.measured_us(measured_us),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ppoc_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.edge_rising(edge_rising),
		.capture_value(capture_value),
		.empty(empty),
		.pop(pop),
		.status(status),
		.measured_us(measured_us),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("pulse_period_ontime_capture test failed");
			$finish;
		end
	end

	// result side: pop is held low in random stall bursts
	initial begin
		int hold;
		hold = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				pop = 1'b0;
				hold--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				pop = 1'b0;
				hold = $urandom_range(0, 16);
			end else begin
				pop = 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(logic [1:0] f, logic rising, logic [15:0] cap);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		push = 1'b1;
		func = f;
		edge_rising = rising;
		capture_value = cap;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// hold off until every expected result is back, then let the back end settle
	task automatic drain();
		push = 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic apply_settings(logic m, logic [7:0] tick, logic [31:0] lim);
		drain();
		write_reg(CfgMeasureMode, {31'd0, m});
		write_reg(CfgTickTimeUs, {24'd0, tick});
		write_reg(CfgTimeoutLimit, lim);
		cur_mode = m;
	endtask

	function automatic logic [15:0] pick_cap();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// start, first rising edge, some wraps with noise, then the closing edge
	task automatic measure_session();
		int wraps;
		send_item(FuncStart, 1'($urandom), 16'($urandom));
		repeat ($urandom_range(0, 2)) send_item(FuncPoll, 1'($urandom), 16'($urandom));
		if ($urandom_range(0, 3) == 0)
			send_item(FuncEdge, 1'b0, pick_cap());
		send_item(FuncEdge, 1'b1, pick_cap());
		wraps = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
		repeat (wraps) begin
			send_item(FuncOverflow, 1'($urandom), 16'($urandom));
			if ($urandom_range(0, 4) == 0)
				send_item(FuncPoll, 1'($urandom), 16'($urandom));
			// edge of the wrong polarity for the current mode
			if ($urandom_range(0, 5) == 0)
				send_item(FuncEdge, cur_mode, pick_cap());
		end
		send_item(FuncEdge, !cur_mode, pick_cap());
	endtask

	initial begin
		int phase_end;
		arst_n = 1'b0;
		push = 1'b0;
		func = FuncStart;
		edge_rising = 1'b0;
		capture_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CfgMeasureMode;
		cfg_data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: period mode, 4 us per tick
		send_item(FuncPoll, 1'b0, 16'h0000);
		send_item(FuncOverflow, 1'b1, 16'hFFFF);
		send_item(FuncEdge, 1'b1, 16'h1234);
		send_item(FuncStart, 1'b0, 16'h0000);
		send_item(FuncOverflow, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b0, 16'd5);
		send_item(FuncEdge, 1'b1, 16'd100);
		send_item(FuncEdge, 1'b0, 16'd200);
		send_item(FuncOverflow, 1'b0, 16'h0000);
		send_item(FuncOverflow, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b1, 16'd50);
		send_item(FuncStart, 1'b1, 16'hFFFF);
		send_item(FuncEdge, 1'b1, 16'hFFFF);
		send_item(FuncEdge, 1'b1, 16'h0000);
		send_item(FuncStart, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b1, 16'h0000);
		send_item(FuncStart, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b1, 16'h0000);
		send_item(FuncEdge, 1'b1, 16'hFFFF);

		// on-time mode, short timeout
		apply_settings(1'b1, 8'd255, 32'd3);
		send_item(FuncStart, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b1, 16'd7);
		send_item(FuncEdge, 1'b1, 16'd9);
		send_item(FuncEdge, 1'b0, 16'd9);
		send_item(FuncStart, 1'b0, 16'h0000);
		repeat (3) send_item(FuncPoll, 1'b1, 16'h0000);

		// enough wraps that the scaled result saturates
		apply_settings(1'b1, 8'd255, 32'hFFFF_FFFF);
		quiet = 1'b1;
		send_item(FuncStart, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b1, 16'h0000);
		repeat (260) send_item(FuncOverflow, 1'b0, 16'h0000);
		send_item(FuncEdge, 1'b0, 16'hFFFF);
		quiet = 1'b0;

		for (int p = 0; p < Phases; p++) begin
			case (p)
				0: apply_settings(1'b0, 8'd1, 32'hFFFF_FFFF);
				1: apply_settings(1'b1, 8'd255, 32'd1);
				2: apply_settings(1'b0, 8'd0, 32'd0);
				default: apply_settings(1'($urandom), 8'($urandom_range(1, 255)),
					32'($urandom_range(2, 25)));
			endcase
			quiet = (p == Phases - 1);
			phase_end = items_sent + ItemsPerPhase;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) < 8)
					measure_session();
				else
					send_item(2'($urandom), 1'($urandom), 16'($urandom));
			end
		end

		drain();
		if (mismatches == 0)
			$display("pulse_period_ontime_capture test passed");
		else
			$display("pulse_period_ontime_capture test failed");
		$finish;
	end

endmodule
